@@ hdl/gmcp_pkg.sv @@
// Package: sizes, distance constants and state codes of the grid path unit.
package gmcp_pkg;

  localparam int MAX_SIDE = 128;
  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int IDX_W    = $clog2(CELLS);
  localparam int TOT_W    = $clog2(CELLS + 1);
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int CRD_W    = $clog2(MAX_SIDE);
  localparam int COST_W   = 4;
  localparam int DIST_W   = 18;
  localparam int OUT_W    = 12;
  localparam int CFG_W    = 8;
  localparam int ADDR_W   = 3;

  localparam logic [DIST_W-1:0] DIST_INF    = {DIST_W{1'b1}};
  localparam logic [OUT_W-1:0]  OUT_MAX     = {OUT_W{1'b1}};
  localparam logic [CFG_W-1:0]  SIDE_RESET  = CFG_W'(128);
  localparam logic [ADDR_W-1:0] REG_SIDE    = '0;

  // Neighbour read order within one cell visit
  localparam logic [2:0] PH_OWN   = 3'd0;
  localparam logic [2:0] PH_UP    = 3'd1;
  localparam logic [2:0] PH_DOWN  = 3'd2;
  localparam logic [2:0] PH_LEFT  = 3'd3;
  localparam logic [2:0] PH_RIGHT = 3'd4;
  localparam logic [2:0] PH_LAST  = 3'd5;

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_INIT = 6'b000010,
    S_REL  = 6'b000100,
    S_WB   = 6'b001000,
    S_FIN  = 6'b010000,
    S_FIN2 = 6'b100000
  } state_t;

endpackage

@@ hdl/grid_min_cost_path_unit.sv @@
// Top level: grid cost loader and memory-based four-neighbour path relaxation.
//
//  channel | ports                           | moves
//  --------+---------------------------------+---------------------------------
//  in      | in_valid/in_ready               | in_cell_cost, in_last_cell
//  out     | out_valid/out_ready             | out_min_cost
//  cfg     | psel/penable/pwrite/paddr/...   | grid_side at byte address 0
//
// Loading takes one cell per cycle through the cost RAM write port while in_ready is high.
// After the last cell: an initialising pass over the grid, then sweeps that visit each
// cell with five reads on the single distance RAM port, a compare and a write back,
// repeated until a sweep changes nothing, then the result is fetched from the last cell.
// in_ready is low from the last cell until the result is in the output register.
// Synchronous active-low reset clears control state; RAM contents are not cleared.
module grid_min_cost_path_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [gmcp_pkg::COST_W-1:0]    in_cell_cost,
  input  logic                           in_last_cell,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gmcp_pkg::OUT_W-1:0]     out_min_cost,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gmcp_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int IW = gmcp_pkg::IDX_W;
  localparam int TW = gmcp_pkg::TOT_W;
  localparam int SW = gmcp_pkg::SIDE_W;
  localparam int CW = gmcp_pkg::CRD_W;
  localparam int DW = gmcp_pkg::DIST_W;

  gmcp_pkg::state_t state_r, state_nxt;

  logic [gmcp_pkg::CFG_W-1:0] side_cfg_r;
  logic [TW-1:0]  load_pos_r;
  logic [IW-1:0]  idx_r;
  logic [CW-1:0]  row_r, col_r;
  logic [2:0]     ph_r;
  logic           ok_d_r;
  logic           changed_r;
  logic [DW-1:0]  own_r, best_r;
  logic           out_valid_r;
  logic [gmcp_pkg::OUT_W-1:0] out_min_cost_r;

  // Side in use and derived sizes
  logic [SW-1:0]  side;
  logic [TW-1:0]  total;
  logic [IW-1:0]  last_idx;
  logic [CW-1:0]  last_crd;
  logic [IW-1:0]  side_i;

  always_comb begin
    if (side_cfg_r == '0) begin
      side = SW'(1);
    end else if (32'(side_cfg_r) > 32'(gmcp_pkg::MAX_SIDE)) begin
      side = SW'(gmcp_pkg::MAX_SIDE);
    end else begin
      side = SW'(side_cfg_r);
    end
  end

  assign total    = TW'(side) * TW'(side);
  assign last_idx = IW'(total - TW'(1));
  assign last_crd = CW'(side - SW'(1));
  assign side_i   = IW'(side);

  // Configuration port
  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr == gmcp_pkg::REG_SIDE) ? 32'(side_cfg_r) : '0;

  // RAM ports
  logic          cost_we;
  logic [IW-1:0] cost_addr;
  logic [gmcp_pkg::COST_W-1:0] cost_rdata;
  logic          dist_we;
  logic [IW-1:0] dist_addr;
  logic [DW-1:0] dist_wdata, dist_rdata;

  gmcp_ram #(.WIDTH(gmcp_pkg::COST_W), .DEPTH(gmcp_pkg::CELLS)) u_cost_ram (
    .clk   (clk),
    .we    (cost_we),
    .addr  (cost_addr),
    .wdata (in_cell_cost),
    .rdata (cost_rdata)
  );

  gmcp_ram #(.WIDTH(DW), .DEPTH(gmcp_pkg::CELLS)) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .addr  (dist_addr),
    .wdata (dist_wdata),
    .rdata (dist_rdata)
  );

  logic in_acc;
  assign in_ready = state_r == gmcp_pkg::S_LOAD;
  assign in_acc   = in_valid & in_ready;

  // Neighbour address and validity for the current phase
  logic [IW-1:0] nb_addr;
  logic          nb_ok;
  always_comb begin
    nb_addr = idx_r;
    nb_ok   = 1'b1;
    case (ph_r)
      gmcp_pkg::PH_OWN: begin
        nb_addr = idx_r;
        nb_ok   = 1'b1;
      end
      gmcp_pkg::PH_UP: begin
        nb_addr = idx_r - side_i;
        nb_ok   = row_r != '0;
      end
      gmcp_pkg::PH_DOWN: begin
        nb_addr = idx_r + side_i;
        nb_ok   = row_r != last_crd;
      end
      gmcp_pkg::PH_LEFT: begin
        nb_addr = idx_r - IW'(1);
        nb_ok   = col_r != '0;
      end
      gmcp_pkg::PH_RIGHT: begin
        nb_addr = idx_r + IW'(1);
        nb_ok   = col_r != last_crd;
      end
      default: begin
        nb_addr = idx_r;
        nb_ok   = 1'b0;
      end
    endcase
  end

  // Candidate through the neighbour whose data returns this cycle
  logic [DW:0]   cand_sum;
  logic [DW-1:0] cand;
  assign cand_sum = {1'b0, dist_rdata} + (DW+1)'(cost_rdata);
  assign cand     = (cand_sum > (DW+1)'(gmcp_pkg::DIST_INF)) ? gmcp_pkg::DIST_INF
                                                             : cand_sum[DW-1:0];

  logic upd, idx_last, out_free;
  assign upd      = best_r < own_r;
  assign idx_last = idx_r == last_idx;
  assign out_free = ~out_valid_r | out_ready;

  // RAM control
  always_comb begin
    cost_we    = 1'b0;
    cost_addr  = idx_r;
    dist_we    = 1'b0;
    dist_addr  = idx_r;
    dist_wdata = best_r;
    case (state_r)
      gmcp_pkg::S_LOAD: begin
        cost_addr = load_pos_r[IW-1:0];
        cost_we   = in_acc & (load_pos_r < total);
      end
      gmcp_pkg::S_INIT: begin
        dist_we    = 1'b1;
        dist_wdata = (idx_r == '0) ? '0 : gmcp_pkg::DIST_INF;
      end
      gmcp_pkg::S_REL: begin
        dist_addr = nb_addr;
      end
      gmcp_pkg::S_WB: begin
        dist_we = upd;
      end
      gmcp_pkg::S_FIN, gmcp_pkg::S_FIN2: begin
        dist_addr = last_idx;
      end
      default: begin
        dist_we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gmcp_pkg::S_LOAD: if (in_acc && in_last_cell) state_nxt = gmcp_pkg::S_INIT;
      gmcp_pkg::S_INIT: if (idx_last) state_nxt = gmcp_pkg::S_REL;
      gmcp_pkg::S_REL:  if (ph_r == gmcp_pkg::PH_LAST) state_nxt = gmcp_pkg::S_WB;
      gmcp_pkg::S_WB: begin
        if (idx_last && !(changed_r | upd)) begin
          state_nxt = gmcp_pkg::S_FIN;
        end else begin
          state_nxt = gmcp_pkg::S_REL;
        end
      end
      gmcp_pkg::S_FIN:  state_nxt = gmcp_pkg::S_FIN2;
      gmcp_pkg::S_FIN2: if (out_free) state_nxt = gmcp_pkg::S_LOAD;
      default:          state_nxt = gmcp_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gmcp_pkg::S_LOAD;
      side_cfg_r  <= gmcp_pkg::SIDE_RESET;
      load_pos_r  <= '0;
      idx_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      ph_r        <= gmcp_pkg::PH_OWN;
      ok_d_r      <= 1'b0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && paddr == gmcp_pkg::REG_SIDE) begin
        side_cfg_r <= pwdata[gmcp_pkg::CFG_W-1:0];
      end
      // Output register: set on a finished solve, cleared on its transaction
      if (state_r == gmcp_pkg::S_FIN2 && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        gmcp_pkg::S_LOAD: begin
          if (in_acc) begin
            if (in_last_cell) begin
              load_pos_r <= '0;
            end else if (load_pos_r < total) begin
              load_pos_r <= load_pos_r + TW'(1);
            end
          end
          idx_r <= '0;
        end
        gmcp_pkg::S_INIT: begin
          if (idx_last) begin
            idx_r     <= '0;
            row_r     <= '0;
            col_r     <= '0;
            ph_r      <= gmcp_pkg::PH_OWN;
            changed_r <= 1'b0;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        gmcp_pkg::S_REL: begin
          ok_d_r <= nb_ok;
          ph_r   <= ph_r + 3'd1;
        end
        gmcp_pkg::S_WB: begin
          ph_r <= gmcp_pkg::PH_OWN;
          if (idx_last) begin
            idx_r     <= '0;
            row_r     <= '0;
            col_r     <= '0;
            changed_r <= 1'b0;
          end else begin
            idx_r     <= idx_r + IW'(1);
            changed_r <= changed_r | upd;
            if (col_r == last_crd) begin
              col_r <= '0;
              row_r <= row_r + CW'(1);
            end else begin
              col_r <= col_r + CW'(1);
            end
          end
        end
        default: begin
          ph_r <= ph_r;
        end
      endcase
    end
  end

  // Distance datapath: own value, then running minimum over neighbours
  always_ff @(posedge clk) begin
    if (state_r == gmcp_pkg::S_REL) begin
      if (ph_r == gmcp_pkg::PH_UP) begin
        own_r  <= dist_rdata;
        best_r <= dist_rdata;
      end else if (ph_r != gmcp_pkg::PH_OWN && ok_d_r && cand < best_r) begin
        best_r <= cand;
      end
    end
    if (state_r == gmcp_pkg::S_FIN2 && out_free) begin
      out_min_cost_r <= (dist_rdata > DW'(gmcp_pkg::OUT_MAX)) ? gmcp_pkg::OUT_MAX
                                                             : dist_rdata[gmcp_pkg::OUT_W-1:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_min_cost = out_min_cost_r;

endmodule

@@ hdl/gmcp_ram.sv @@
// Generic single-port RAM with registered read.
module gmcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ dv/grid_min_cost_path_unit_test.sv @@
// Testbench: grid path unit driven by directed rows and random grids, checked by a predictor.
module grid_min_cost_path_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 20_000_000;

  typedef enum int {ROW_CELL, ROW_CFG} row_kind_t;
  typedef struct {
    row_kind_t                  kind;
    int                         data;   // cell cost, or register value for a write
    bit                         last;
    int                         reps;
    bit                         typed;
    logic [gmcp_pkg::OUT_W-1:0] want;
  } plan_row_t;

  // Directed plan; typed results only where they are obvious
  localparam int PLAN_LEN = 22;
  plan_row_t plan [PLAN_LEN] = '{
    // reset side of 128, uniform cost one: corner distance is 2*127
    '{ROW_CELL, 1, 1'b0, gmcp_pkg::CELLS-1, 1'b0, '0},
    '{ROW_CELL, 1, 1'b1, 1, 1'b1, 12'd254},
    // side above the limit is clamped, early last cell after three loads
    '{ROW_CFG, 255, 1'b0, 1, 1'b0, '0},
    '{ROW_CELL, 9, 1'b0, 3, 1'b0, '0},
    '{ROW_CELL, 15, 1'b1, 1, 1'b0, '0},
    // side zero is used as one: single cell gives zero
    '{ROW_CFG, 0, 1'b0, 1, 1'b0, '0},
    '{ROW_CELL, 7, 1'b1, 1, 1'b1, 12'd0},
    '{ROW_CFG, 1, 1'b0, 1, 1'b0, '0},
    '{ROW_CELL, 15, 1'b1, 1, 1'b1, 12'd0},
    // two by two, costs above nine taken as given
    '{ROW_CFG, 2, 1'b0, 1, 1'b0, '0},
    '{ROW_CELL, 0, 1'b0, 1, 1'b0, '0},
    '{ROW_CELL, 15, 1'b0, 2, 1'b0, '0},
    '{ROW_CELL, 0, 1'b1, 1, 1'b1, 12'd15},
    // extra cells beyond the grid are dropped
    '{ROW_CELL, 1, 1'b0, 4, 1'b0, '0},
    '{ROW_CELL, 15, 1'b0, 2, 1'b0, '0},
    '{ROW_CELL, 3, 1'b1, 1, 1'b1, 12'd2},
    '{ROW_CELL, 0, 1'b0, 3, 1'b0, '0},
    '{ROW_CELL, 0, 1'b1, 1, 1'b1, 12'd0},
    // early last cell on a small grid reuses older costs
    '{ROW_CFG, 3, 1'b0, 1, 1'b0, '0},
    '{ROW_CELL, 8, 1'b1, 1, 1'b0, '0},
    '{ROW_CELL, 4, 1'b0, 8, 1'b0, '0},
    '{ROW_CELL, 12, 1'b1, 1, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [gmcp_pkg::COST_W-1:0] in_cell_cost = '0;
  logic in_last_cell = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [gmcp_pkg::OUT_W-1:0] out_min_cost;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [gmcp_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  grid_min_cost_path_unit dut (.*);

  // Predictor state
  logic [gmcp_pkg::CFG_W-1:0]  side_reg = gmcp_pkg::SIDE_RESET;
  logic [gmcp_pkg::COST_W-1:0] cost_mem [gmcp_pkg::CELLS];
  int unsigned                 dist_mem [gmcp_pkg::CELLS];
  int unsigned                 fill_pos = 0;

  logic [gmcp_pkg::OUT_W-1:0] min_cost_due [$];
  int errors = 0;
  int results_seen = 0;
  int cells_sent = 0;
  int burst_left = 0;
  longint cycles = 0;

  initial forever #2 clk = ~clk;

  // Clamped side as the block uses it
  function automatic int unsigned side_used();
    if (side_reg == 0) return 1;
    if (side_reg > gmcp_pkg::MAX_SIDE) return gmcp_pkg::MAX_SIDE;
    return side_reg;
  endfunction

  function automatic bit relax_one(int unsigned idx, int unsigned side);
    int r, c, nr, nc;
    int unsigned best, cand;
    if (idx == 0) return 1'b0;
    r = idx / side;
    c = idx % side;
    best = dist_mem[idx];
    for (int k = 0; k < 4; k++) begin
      nr = r + ((k == 0) ? -1 : (k == 1) ? 1 : 0);
      nc = c + ((k == 2) ? -1 : (k == 3) ? 1 : 0);
      if (nr < 0 || nc < 0 || nr >= int'(side) || nc >= int'(side)) continue;
      cand = dist_mem[nr * side + nc] + cost_mem[idx];
      if (cand > gmcp_pkg::DIST_INF) cand = gmcp_pkg::DIST_INF;
      if (cand < best) best = cand;
    end
    if (best < dist_mem[idx]) begin
      dist_mem[idx] = best;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Alternating sweeps until a sweep changes nothing
  function automatic logic [gmcp_pkg::OUT_W-1:0] path_cost(int unsigned side);
    int unsigned total;
    bit fwd, moved;
    total = side * side;
    fwd = 1'b1;
    for (int unsigned i = 0; i < total; i++) dist_mem[i] = gmcp_pkg::DIST_INF;
    dist_mem[0] = 0;
    do begin
      moved = 1'b0;
      if (fwd) begin
        for (int unsigned i = 0; i < total; i++) moved |= relax_one(i, side);
      end else begin
        for (int unsigned i = total; i > 0; i--) moved |= relax_one(i - 1, side);
      end
      fwd = !fwd;
    end while (moved);
    if (dist_mem[total-1] > gmcp_pkg::OUT_MAX) return gmcp_pkg::OUT_MAX;
    return dist_mem[total-1][gmcp_pkg::OUT_W-1:0];
  endfunction

  // Model one accepted cell; returns the due result when it completes a grid
  function automatic logic [gmcp_pkg::OUT_W-1:0] take_cell(
      logic [gmcp_pkg::COST_W-1:0] cost, bit last);
    int unsigned side;
    logic [gmcp_pkg::OUT_W-1:0] res;
    side = side_used();
    if (fill_pos < side * side) begin
      cost_mem[fill_pos] = cost;
      fill_pos++;
    end
    res = '0;
    if (last) begin
      res = path_cost(side);
      min_cost_due.push_back(res);
      fill_pos = 0;
    end
    return res;
  endfunction

  // Offer one cell, hold until the transaction, then pace the next one
  task automatic send_cell(logic [gmcp_pkg::COST_W-1:0] cost, bit last, bit typed,
                           logic [gmcp_pkg::OUT_W-1:0] want);
    logic [gmcp_pkg::OUT_W-1:0] got;
    in_valid <= 1'b1;
    in_cell_cost <= cost;
    in_last_cell <= last;
    do @(posedge clk); while (!in_ready);
    got = take_cell(cost, last);
    cells_sent++;
    if (typed && got !== want) begin
      $error("typed row min_cost: expected %0d, predictor %0d", want, got);
      errors++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // Register write once the block is idle
  task automatic write_side(int value);
    in_valid <= 1'b0;
    while (min_cost_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= gmcp_pkg::REG_SIDE;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    side_reg = value[gmcp_pkg::CFG_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [gmcp_pkg::COST_W-1:0] pick_cost();
    if ($urandom_range(0, 4) == 0) return gmcp_pkg::COST_W'($urandom_range(0, 15));
    return gmcp_pkg::COST_W'($urandom_range(0, 9));
  endfunction

  // Stimulus
  initial begin
    int unsigned total, n;
    int grids;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_side(plan[i].data);
      end else begin
        for (int k = 0; k < plan[i].reps; k++)
          send_cell(gmcp_pkg::COST_W'(plan[i].data), plan[i].last, plan[i].typed,
                    plan[i].want);
      end
    end

    // Random grids: mostly well formed, some cut short or overrun
    while (cells_sent < gmcp_pkg::CELLS + 750 || results_seen + min_cost_due.size() < 40) begin
      if ($urandom_range(0, 9) == 0) write_side($urandom_range(9, 16));
      else if ($urandom_range(0, 19) == 0) write_side(0);
      else write_side($urandom_range(1, 8));
      total = side_used() * side_used();
      grids = $urandom_range(2, 5);
      repeat (grids) begin
        case ($urandom_range(0, 9))
          0, 1: n = $urandom_range(1, total);
          2: n = total + $urandom_range(1, 5);
          default: n = total;
        endcase
        for (int unsigned k = 1; k <= n; k++) send_cell(pick_cost(), k == n, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (min_cost_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Receiver: stretches of full, random and sparse readiness, one long hold-off
  initial begin
    int mode, len, hold_left;
    bit held;
    held = 1'b0;
    hold_left = 0;
    mode = 0;
    len = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 20) begin
        held = 1'b1;
        hold_left = 20000;
      end
      if (len == 0) begin
        mode = $urandom_range(0, 2);
        len = $urandom_range(1, 40);
      end
      len--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Result check against the oldest due value
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (min_cost_due.size() == 0) begin
        $error("min_cost: unexpected result %0d", out_min_cost);
        errors++;
      end else begin
        if (out_min_cost !== min_cost_due[0]) begin
          $error("min_cost: expected %0d, actual %0d", min_cost_due[0], out_min_cost);
          errors++;
        end
        void'(min_cost_due.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
